// ===== rtl/sht_pkg.sv =====
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types, byte constants, phase codes and token kinds for the
// SSDP header tokenizer.
// ----------------------------------------------------------------------------
package sht_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // parser phases
    localparam logic [2:0] PH_STOP   = 3'd0;
    localparam logic [2:0] PH_ACTION = 3'd1;
    localparam logic [2:0] PH_SKIPLN = 3'd2;
    localparam logic [2:0] PH_LF     = 3'd3;
    localparam logic [2:0] PH_NAME   = 3'd4;
    localparam logic [2:0] PH_SPACE  = 3'd5;
    localparam logic [2:0] PH_VALUE  = 3'd6;
    localparam logic [2:0] PH_LF_END = 3'd7;

    // token kinds
    localparam logic [3:0] K_SKIP     = 4'd0;
    localparam logic [3:0] K_ACT      = 4'd1;
    localparam logic [3:0] K_ACT_END  = 4'd2;
    localparam logic [3:0] K_NAME     = 4'd3;
    localparam logic [3:0] K_NAME_END = 4'd4;
    localparam logic [3:0] K_VAL      = 4'd5;
    localparam logic [3:0] K_VAL_END  = 4'd6;
    localparam logic [3:0] K_DROP     = 4'd7;
    localparam logic [3:0] K_DONE     = 4'd8;
    localparam logic [3:0] K_ERR      = 4'd9;
    localparam logic [3:0] K_INCOMPL  = 4'd10;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] byte_out;
    } t_tok;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - CASE_OFS;
        end
        return r;
    endfunction

endpackage

// ===== rtl/sht_decode.sv =====
// ----------------------------------------------------------------------------
// sht_decode
// Per-byte tokenizer step: classifies one byte against the current parse
// phase and gives the token and the following phase.
// ----------------------------------------------------------------------------
module sht_decode
    import sht_pkg::*;
(
    input  logic [2:0] i_phase,
    input  logic [7:0] i_byte,
    input  logic       i_first,
    input  logic       i_last,
    output logic [2:0] o_phase,
    output t_tok       o_tok
);

    logic [2:0] w_ph;
    logic [2:0] w_nph;
    logic [3:0] w_kind;
    logic [7:0] w_bo;

    always_comb begin
        w_ph   = i_first ? PH_ACTION : i_phase;
        w_nph  = w_ph;
        w_kind = K_SKIP;
        w_bo   = i_byte;
        unique case (w_ph)
            PH_STOP: begin
                w_nph = PH_STOP;
            end
            PH_ACTION: begin
                if (i_byte == CH_SPACE || i_byte == CH_SLASH) begin
                    w_kind = K_ACT_END;
                    w_nph  = PH_SKIPLN;
                end else begin
                    w_kind = K_ACT;
                end
            end
            PH_SKIPLN: begin
                if (i_byte == CH_CR) begin
                    w_nph = PH_LF;
                end
            end
            PH_LF: begin
                if (i_byte == CH_LF) begin
                    w_nph = PH_NAME;
                end else begin
                    w_kind = K_ERR;
                    w_nph  = PH_STOP;
                end
            end
            PH_NAME: begin
                if (i_byte == CH_CR) begin
                    w_kind = K_DROP;
                    w_nph  = PH_LF_END;
                end else if (i_byte == CH_COLON) begin
                    w_kind = K_NAME_END;
                    w_nph  = PH_SPACE;
                end else begin
                    w_kind = K_NAME;
                    w_bo   = upcase(i_byte);
                end
            end
            PH_SPACE: begin
                if (i_byte == CH_CR) begin
                    w_kind = K_VAL_END;
                    w_nph  = PH_LF;
                end else if (i_byte != CH_SPACE) begin
                    w_kind = K_VAL;
                    w_nph  = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (i_byte == CH_CR) begin
                    w_kind = K_VAL_END;
                    w_nph  = PH_LF;
                end else begin
                    w_kind = K_VAL;
                end
            end
            PH_LF_END: begin
                w_kind = (i_byte == CH_LF) ? K_DONE : K_ERR;
                w_nph  = PH_STOP;
            end
            default: begin
                w_nph = PH_STOP;
            end
        endcase

        // end of datagram without a finished message
        if (i_last && w_kind != K_DONE && w_kind != K_ERR) begin
            if (i_first || i_phase != PH_STOP) begin
                w_kind = K_INCOMPL;
                w_bo   = i_byte;
            end
            w_nph = PH_STOP;
        end
    end

    assign o_phase        = w_nph;
    assign o_tok.kind     = w_kind;
    assign o_tok.byte_out = w_bo;

endmodule

// ===== rtl/ssdp_header_tokenizer.sv =====
// ----------------------------------------------------------------------------
// ssdp_header_tokenizer
// Tags each byte of an SSDP/HTTPU message with its role (action, header
// name, value, delimiters, skip, drop, done, error, incomplete).
// ----------------------------------------------------------------------------
//  channel   dir  tdata            tuser        tlast
//  s_axis    in   [7:0] byte_in    [0] first    last
//  m_axis    out  [7:0] byte_out   [3:0] kind   -
//
//  Path: input register, decode, result register.
//  One item per cycle sustained while m_axis is ready; the phase
//  register updates as an item moves into the result register.
//  Stalls on m_axis hold the result; the input register absorbs one more.
//  Synchronous active-low reset: pipeline empty, phase stopped.
// ----------------------------------------------------------------------------
module ssdp_header_tokenizer
    import sht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
    input  logic       s_axis_tuser,   // [0] first
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] byte_out
    output logic [3:0] m_axis_tuser    // [3:0] kind
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_first;
    logic       r_last;
    logic [2:0] r_phase;
    logic       r_out_valid;
    t_tok       r_tok;

    logic [2:0] n_phase;
    t_tok       n_tok;
    logic       w_adv;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    sht_decode u_decode (
        .i_phase (r_phase),
        .i_byte  (r_byte),
        .i_first (r_first),
        .i_last  (r_last),
        .o_phase (n_phase),
        .o_tok   (n_tok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte  <= s_axis_tdata;
            r_first <= s_axis_tuser;
            r_last  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_STOP;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tok <= n_tok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_tok.byte_out;
    assign m_axis_tuser  = r_tok.kind;

    // terminal tokens always leave the parser stopped
    a_term_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (n_tok.kind == K_DONE || n_tok.kind == K_ERR ||
                  n_tok.kind == K_INCOMPL) |=> r_phase == PH_STOP)
        else $error("terminal token did not stop parser");

    // a datagram end always stops the parser
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_last |=> r_phase == PH_STOP)
        else $error("last byte did not stop parser");

    // name bytes leave upper-cased
    a_name_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == K_NAME |->
            !(m_axis_tdata >= CH_LOW_A && m_axis_tdata <= CH_LOW_Z))
        else $error("name byte not upper-cased");

    // phase stays put while no item advances
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_phase))
        else $error("phase changed without an item");

endmodule
